>>> hw/rtl/csl_pkg.sv
`default_nettype none

package csl_pkg;

    localparam int LINE_BITS   = 24;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int KIND_BITS   = 6;
    localparam int CHAR_BITS   = 8;
    localparam int PREFIX_LEN  = 6;
    localparam int MAX_TOKENS  = 3;

    localparam int TOKEN_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS;
    localparam int TDATA_BITS = ((TOKEN_BITS + 7) / 8) * 8;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_INTDOT, M_FLOAT, M_SLASH, M_COMMENT,
        M_LT, M_GT, M_ASSIGN, M_BANG, M_AMP, M_PIPE
    } mode_t;

    // Token kinds
    localparam logic [KIND_BITS-1:0] TK_EOF      = 6'd0;
    localparam logic [KIND_BITS-1:0] TK_ERR      = 6'd1;
    localparam logic [KIND_BITS-1:0] TK_IDENT    = 6'd2;
    localparam logic [KIND_BITS-1:0] TK_INT      = 6'd3;
    localparam logic [KIND_BITS-1:0] TK_FLOAT    = 6'd4;
    localparam logic [KIND_BITS-1:0] TK_KW_BREAK = 6'd5;
    localparam logic [KIND_BITS-1:0] TK_KW_BOOL  = 6'd6;
    localparam logic [KIND_BITS-1:0] TK_KW_ELSE  = 6'd7;
    localparam logic [KIND_BITS-1:0] TK_KW_FALSE = 6'd8;
    localparam logic [KIND_BITS-1:0] TK_KW_FLOAT = 6'd9;
    localparam logic [KIND_BITS-1:0] TK_KW_IF    = 6'd10;
    localparam logic [KIND_BITS-1:0] TK_KW_INT   = 6'd11;
    localparam logic [KIND_BITS-1:0] TK_KW_NEW   = 6'd12;
    localparam logic [KIND_BITS-1:0] TK_KW_RET   = 6'd13;
    localparam logic [KIND_BITS-1:0] TK_KW_SIZE  = 6'd14;
    localparam logic [KIND_BITS-1:0] TK_KW_TRUE  = 6'd15;
    localparam logic [KIND_BITS-1:0] TK_KW_VOID  = 6'd16;
    localparam logic [KIND_BITS-1:0] TK_KW_WHILE = 6'd17;
    localparam logic [KIND_BITS-1:0] TK_LPAREN   = 6'd18;
    localparam logic [KIND_BITS-1:0] TK_RPAREN   = 6'd19;
    localparam logic [KIND_BITS-1:0] TK_LBRACE   = 6'd20;
    localparam logic [KIND_BITS-1:0] TK_RBRACE   = 6'd21;
    localparam logic [KIND_BITS-1:0] TK_LBRACK   = 6'd22;
    localparam logic [KIND_BITS-1:0] TK_RBRACK   = 6'd23;
    localparam logic [KIND_BITS-1:0] TK_SEMI     = 6'd24;
    localparam logic [KIND_BITS-1:0] TK_COMMA    = 6'd25;
    localparam logic [KIND_BITS-1:0] TK_DOT      = 6'd26;
    localparam logic [KIND_BITS-1:0] TK_PLUS     = 6'd27;
    localparam logic [KIND_BITS-1:0] TK_MINUS    = 6'd28;
    localparam logic [KIND_BITS-1:0] TK_STAR     = 6'd29;
    localparam logic [KIND_BITS-1:0] TK_SLASH    = 6'd30;
    localparam logic [KIND_BITS-1:0] TK_PERCENT  = 6'd31;
    localparam logic [KIND_BITS-1:0] TK_LT       = 6'd32;
    localparam logic [KIND_BITS-1:0] TK_LE       = 6'd33;
    localparam logic [KIND_BITS-1:0] TK_GT       = 6'd34;
    localparam logic [KIND_BITS-1:0] TK_GE       = 6'd35;
    localparam logic [KIND_BITS-1:0] TK_ASSIGN   = 6'd36;
    localparam logic [KIND_BITS-1:0] TK_EQ       = 6'd37;
    localparam logic [KIND_BITS-1:0] TK_BANG     = 6'd38;
    localparam logic [KIND_BITS-1:0] TK_NE       = 6'd39;
    localparam logic [KIND_BITS-1:0] TK_ANDAND   = 6'd40;
    localparam logic [KIND_BITS-1:0] TK_OROR     = 6'd41;

    // Control bytes
    localparam logic [CHAR_BITS-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR  = 8'h0D;

    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    // First bytes of the pending identifier, byte 0 in the lowest lane
    typedef logic [PREFIX_LEN-1:0][CHAR_BITS-1:0] kw_prefix_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
    } tok_t;

    function automatic tok_t mk_tok(input logic [KIND_BITS-1:0] kind,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [LENGTH_BITS-1:0] len);
        tok_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        return t;
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // Whole-word keyword match; lanes above the length are never looked at.
    // Literals are written last byte first since lane 0 is the low lane.
    function automatic logic [KIND_BITS-1:0] kw_kind(input kw_prefix_t p,
                                                     input logic [LENGTH_BITS-1:0] len);
        logic [KIND_BITS-1:0] k;
        k = TK_IDENT;
        if (len == LENGTH_BITS'(2)) begin
            if (p[1:0] == {"f", "i"}) k = TK_KW_IF;
        end else if (len == LENGTH_BITS'(3)) begin
            if (p[2:0] == {"t", "n", "i"}) k = TK_KW_INT;
            else if (p[2:0] == {"w", "e", "n"}) k = TK_KW_NEW;
        end else if (len == LENGTH_BITS'(4)) begin
            if (p[3:0] == {"l", "o", "o", "b"}) k = TK_KW_BOOL;
            else if (p[3:0] == {"e", "s", "l", "e"}) k = TK_KW_ELSE;
            else if (p[3:0] == {"e", "z", "i", "s"}) k = TK_KW_SIZE;
            else if (p[3:0] == {"e", "u", "r", "t"}) k = TK_KW_TRUE;
            else if (p[3:0] == {"d", "i", "o", "v"}) k = TK_KW_VOID;
        end else if (len == LENGTH_BITS'(5)) begin
            if (p[4:0] == {"k", "a", "e", "r", "b"}) k = TK_KW_BREAK;
            else if (p[4:0] == {"e", "s", "l", "a", "f"}) k = TK_KW_FALSE;
            else if (p[4:0] == {"t", "a", "o", "l", "f"}) k = TK_KW_FLOAT;
            else if (p[4:0] == {"e", "l", "i", "h", "w"}) k = TK_KW_WHILE;
        end else if (len == LENGTH_BITS'(6)) begin
            if (p[5:0] == {"n", "r", "u", "t", "e", "r"}) k = TK_KW_RET;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/c_subset_lexer_core.sv
`default_nettype none

// A byte request is held in the input register, and its tokens are registered in the token buffer.
// Throughput: one byte per cycle while each byte yields at most one token and the master side
// is ready; a byte that closes several tokens (up to three) holds the input while the token
// buffer drains them, one token per cycle while the master side is ready.
// Reset (rst_n low, async): line 1, offset 0, scanner idle, all buffers empty.
module c_subset_lexer_core (
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    // slave side: one source byte per request
    input  wire  logic                           s_axis_tvalid,
    output       logic                           s_axis_tready,
    input  wire  logic [7:0]                     s_axis_tdata,  // [7:0] char_in
    input  wire  logic                           s_axis_tuser,  // [0] end_of_input
    // master side: one token per request
    output       logic                           m_axis_tvalid,
    input  wire  logic                           m_axis_tready,
    // [5:0] token_kind, [29:6] token_line, [61:30] token_start,
    // [77:62] token_length, [79:78] zero
    output       logic [csl_pkg::TDATA_BITS-1:0] m_axis_tdata,
    output       logic                           m_axis_tlast   // last_of_run
);

    import csl_pkg::*;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                 in_valid_reg;
    logic [CHAR_BITS-1:0] in_char_reg;
    logic                 in_end_reg;

    // ---------------------------------------------------------------
    // Scanner state
    // ---------------------------------------------------------------
    mode_t                  mode_reg,   mode_next;
    logic [LINE_BITS-1:0]   line_reg,   line_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [LENGTH_BITS-1:0] plen_reg,   plen_next;
    kw_prefix_t             kwp_reg,    kwp_next;
    logic                   fin_reg,    fin_next;

    // ---------------------------------------------------------------
    // Token buffer: holds the tokens of one byte, drained from slot 0
    // ---------------------------------------------------------------
    tok_t                 buf_reg [MAX_TOKENS];
    logic [LINE_BITS-1:0] buf_line_reg;
    logic [1:0]           cnt_reg;

    logic advance;   // input register moves through the scanner this cycle
    logic pop;       // token leaves on the master side this cycle

    tok_t       tok_new [MAX_TOKENS];
    logic [1:0] n_new;
    logic       used;
    logic       eoi;
    logic [CHAR_BITS-1:0]  ch;
    logic [KIND_BITS-1:0]  op_single;
    logic [CHAR_BITS-1:0]  op_pair;

    assign pop           = (cnt_reg != 2'd0) && m_axis_tready;
    assign advance       = in_valid_reg &&
                           ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tlast  = (cnt_reg == 2'd1);
    assign m_axis_tdata  = TDATA_BITS'({buf_reg[0].len, buf_reg[0].start,
                                        buf_line_reg, buf_reg[0].kind});

    // ---------------------------------------------------------------
    // Scanner step: one byte against the pending token
    // ---------------------------------------------------------------
    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        kwp_next    = kwp_reg;
        fin_next    = fin_reg;
        n_new       = 2'd0;
        used        = 1'b0;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            tok_new[i] = '0;
        end
        ch  = in_char_reg;
        eoi = in_end_reg || (ch == CH_NUL);

        // single and paired forms of the pending operator
        op_single = TK_BANG;
        op_pair   = "=";
        unique case (mode_reg) inside
            M_LT:     op_single = TK_LT;
            M_GT:     op_single = TK_GT;
            M_ASSIGN: op_single = TK_ASSIGN;
            M_AMP:    op_pair   = "&";
            M_PIPE:   op_pair   = "|";
            default:  op_single = TK_BANG;
        endcase

        if (!fin_reg)
        begin
            unique case (mode_reg) inside
                M_IDENT:
                begin
                    if (!eoi && (is_alpha(ch) || is_digit(ch)))
                    begin
                        if (plen_reg < LENGTH_BITS'(PREFIX_LEN))
                        begin
                            kwp_next[plen_reg[2:0]] = ch;
                        end
                        plen_next = (plen_reg == LEN_MAX) ? LEN_MAX : plen_reg + LEN_ONE;
                        used      = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(kw_kind(kwp_reg, plen_reg), pstart_reg,
                                                plen_reg);
                        n_new     = n_new + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_INT:
                begin
                    if (!eoi && is_digit(ch))
                    begin
                        plen_next = (plen_reg == LEN_MAX) ? LEN_MAX : plen_reg + LEN_ONE;
                        used      = 1'b1;
                    end
                    else if (!eoi && (ch == "."))
                    begin
                        mode_next = M_INTDOT;
                        used      = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(TK_INT, pstart_reg, plen_reg);
                        n_new     = n_new + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_INTDOT:
                begin
                    // dot plus digit joins the literal; otherwise int then dot
                    if (!eoi && is_digit(ch))
                    begin
                        plen_next = (plen_reg >= LEN_MAX - LEN_ONE) ? LEN_MAX
                                                                    : plen_reg + LEN_TWO;
                        mode_next = M_FLOAT;
                        used      = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(TK_INT, pstart_reg, plen_reg);
                        n_new = n_new + 2'd1;
                        tok_new[n_new] = mk_tok(TK_DOT, pos_reg - OFFSET_BITS'(1), LEN_ONE);
                        n_new     = n_new + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_FLOAT:
                begin
                    if (!eoi && is_digit(ch))
                    begin
                        plen_next = (plen_reg == LEN_MAX) ? LEN_MAX : plen_reg + LEN_ONE;
                        used      = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(TK_FLOAT, pstart_reg, plen_reg);
                        n_new     = n_new + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_SLASH:
                begin
                    if (!eoi && (ch == "/"))
                    begin
                        mode_next = M_COMMENT;
                        used      = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(TK_SLASH, pstart_reg, LEN_ONE);
                        n_new     = n_new + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_COMMENT:
                begin
                    if (eoi)
                    begin
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        used = 1'b1;
                        if (ch == CH_NL)
                        begin
                            if (line_reg != '1)
                            begin
                                line_next = line_reg + LINE_BITS'(1);
                            end
                            mode_next = M_IDLE;
                        end
                    end
                end
                M_LT, M_GT, M_ASSIGN, M_BANG:
                begin
                    if (!eoi && (ch == "="))
                    begin
                        tok_new[n_new] = mk_tok(op_single + KIND_BITS'(1), pstart_reg, LEN_TWO);
                        used = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(op_single, pstart_reg, LEN_ONE);
                    end
                    n_new     = n_new + 2'd1;
                    mode_next = M_IDLE;
                end
                M_AMP, M_PIPE:
                begin
                    // a lone ampersand or bar is an error of length one
                    if (!eoi && (ch == op_pair))
                    begin
                        tok_new[n_new] = mk_tok((mode_reg == M_AMP) ? TK_ANDAND : TK_OROR,
                                                pstart_reg, LEN_TWO);
                        used = 1'b1;
                    end
                    else
                    begin
                        tok_new[n_new] = mk_tok(TK_ERR, pstart_reg, LEN_ONE);
                    end
                    n_new     = n_new + 2'd1;
                    mode_next = M_IDLE;
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase

            if (eoi)
            begin
                tok_new[n_new] = mk_tok(TK_EOF, pos_reg, LEN_ZERO);
                n_new    = n_new + 2'd1;
                fin_next = 1'b1;
            end
            else
            begin
                if (!used)
                begin
                    // fresh scan of the byte
                    case (ch)
                        " ", CH_TAB, CH_CR:
                        begin
                        end
                        CH_NL:
                        begin
                            if (line_reg != '1)
                            begin
                                line_next = line_reg + LINE_BITS'(1);
                            end
                        end
                        "/", "<", ">", "=", "!", "&", "|":
                        begin
                            pstart_next = pos_reg;
                            plen_next   = LEN_ONE;
                            case (ch)
                                "/":     mode_next = M_SLASH;
                                "<":     mode_next = M_LT;
                                ">":     mode_next = M_GT;
                                "=":     mode_next = M_ASSIGN;
                                "!":     mode_next = M_BANG;
                                "&":     mode_next = M_AMP;
                                default: mode_next = M_PIPE;
                            endcase
                        end
                        "(":
                        begin
                            tok_new[n_new] = mk_tok(TK_LPAREN, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        ")":
                        begin
                            tok_new[n_new] = mk_tok(TK_RPAREN, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "{":
                        begin
                            tok_new[n_new] = mk_tok(TK_LBRACE, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "}":
                        begin
                            tok_new[n_new] = mk_tok(TK_RBRACE, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "[":
                        begin
                            tok_new[n_new] = mk_tok(TK_LBRACK, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "]":
                        begin
                            tok_new[n_new] = mk_tok(TK_RBRACK, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        ";":
                        begin
                            tok_new[n_new] = mk_tok(TK_SEMI, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        ",":
                        begin
                            tok_new[n_new] = mk_tok(TK_COMMA, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        ".":
                        begin
                            tok_new[n_new] = mk_tok(TK_DOT, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "+":
                        begin
                            tok_new[n_new] = mk_tok(TK_PLUS, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "-":
                        begin
                            tok_new[n_new] = mk_tok(TK_MINUS, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "*":
                        begin
                            tok_new[n_new] = mk_tok(TK_STAR, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        "%":
                        begin
                            tok_new[n_new] = mk_tok(TK_PERCENT, pos_reg, LEN_ONE);
                            n_new = n_new + 2'd1;
                        end
                        default:
                        begin
                            if (is_alpha(ch))
                            begin
                                mode_next   = M_IDENT;
                                pstart_next = pos_reg;
                                plen_next   = LEN_ONE;
                                kwp_next[0] = ch;
                            end
                            else if (is_digit(ch))
                            begin
                                mode_next   = M_INT;
                                pstart_next = pos_reg;
                                plen_next   = LEN_ONE;
                            end
                            else
                            begin
                                tok_new[n_new] = mk_tok(TK_ERR, pos_reg, LEN_ONE);
                                n_new = n_new + 2'd1;
                            end
                        end
                    endcase
                end
                pos_next = pos_reg + OFFSET_BITS'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= M_IDLE;
            line_reg     <= LINE_BITS'(1);
            pos_reg      <= '0;
            pstart_reg   <= '0;
            plen_reg     <= '0;
            fin_reg      <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                mode_reg   <= mode_next;
                line_reg   <= line_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                fin_reg    <= fin_next;
                cnt_reg    <= n_new;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
        if (advance)
        begin
            kwp_reg      <= kwp_next;
            buf_line_reg <= line_reg;
            for (int i = 0; i < MAX_TOKENS; i++)
            begin
                buf_reg[i] <= tok_new[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_TOKENS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;

    import csl_pkg::*;

    // tdata layout of one token, lowest field first
    localparam int LINE_LO  = KIND_BITS;
    localparam int START_LO = LINE_LO + LINE_BITS;
    localparam int LEN_LO   = START_LO + OFFSET_BITS;

    localparam int STALL_LIMIT = 2000;  // cycles with no request moving on either side
    localparam int LOG_CAP     = 50;    // mismatch lines printed before going quiet

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } lex_token_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    c_subset_lexer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scanner state mirrored by the predictor (starts in its reset state)
    mode_t                  scan_mode  = M_IDLE;
    logic [LINE_BITS-1:0]   cur_line   = LINE_BITS'(1);
    logic [OFFSET_BITS-1:0] cur_offset = '0;
    logic [OFFSET_BITS-1:0] tok_start  = '0;
    logic [LENGTH_BITS-1:0] tok_len    = '0;
    logic [47:0]            word_text  = '0;  // first six bytes, first byte highest
    logic                   stream_done = 1'b0;

    lex_token_t step_tokens[$];
    lex_token_t expected_tokens[$];

    int  mismatches  = 0;
    int  bytes_sent  = 0;
    int  sink_hold   = 0;
    bit  steady_flow = 1'b0;  // both sides drop their random gaps while set

    string keyword_texts[13] = '{"break", "bool", "else", "false", "float", "if", "int",
                                 "new", "return", "size", "true", "void", "while"};
    string op_texts[26] = '{"(", ")", "{", "}", "[", "]", ";", ",", ".", "+", "-", "*",
                            "/", "%", "<", "<=", ">", ">=", "=", "==", "!", "!=",
                            "&&", "||", "&", "|"};
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string ws_chars   = " \t\015\n";

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [LENGTH_BITS-1:0] grow_len(input logic [LENGTH_BITS-1:0] l,
                                                        input int unsigned by);
        logic [LENGTH_BITS:0] sum;
        sum = {1'b0, l} + (LENGTH_BITS+1)'(by);
        return sum[LENGTH_BITS] ? LEN_MAX : sum[LENGTH_BITS-1:0];
    endfunction

    // Whole-word match only: word_text holds zeros above a short word, and a word
    // longer than six bytes is turned away by its length, so it never equals a keyword.
    function automatic logic [KIND_BITS-1:0] keyword_kind(input logic [47:0] w,
                                                          input logic [LENGTH_BITS-1:0] l);
        if (l > LENGTH_BITS'(6))
            return TK_IDENT;
        case (w)
            "break":  return TK_KW_BREAK;
            "bool":   return TK_KW_BOOL;
            "else":   return TK_KW_ELSE;
            "false":  return TK_KW_FALSE;
            "float":  return TK_KW_FLOAT;
            "if":     return TK_KW_IF;
            "int":    return TK_KW_INT;
            "new":    return TK_KW_NEW;
            "return": return TK_KW_RET;
            "size":   return TK_KW_SIZE;
            "true":   return TK_KW_TRUE;
            "void":   return TK_KW_VOID;
            "while":  return TK_KW_WHILE;
            default:  return TK_IDENT;
        endcase
    endfunction

    task automatic add_token(input logic [KIND_BITS-1:0] kind,
                             input logic [OFFSET_BITS-1:0] start,
                             input logic [LENGTH_BITS-1:0] len);
        step_tokens.push_back('{kind, cur_line, start, len, 1'b0});
    endtask

    task automatic bump_line();
        if (cur_line != '1)
            cur_line = cur_line + 1'b1;
    endtask

    task automatic open_token(input mode_t m);
        scan_mode = m;
        tok_start = cur_offset;
        tok_len   = LEN_ONE;
    endtask

    // A byte seen with nothing pending
    task automatic scan_byte(input logic [7:0] c);
        case (c)
            " ", CH_TAB, CH_CR: ;
            CH_NL: bump_line();
            "/": open_token(M_SLASH);
            "<": open_token(M_LT);
            ">": open_token(M_GT);
            "=": open_token(M_ASSIGN);
            "!": open_token(M_BANG);
            "&": open_token(M_AMP);
            "|": open_token(M_PIPE);
            "(": add_token(TK_LPAREN, cur_offset, LEN_ONE);
            ")": add_token(TK_RPAREN, cur_offset, LEN_ONE);
            "{": add_token(TK_LBRACE, cur_offset, LEN_ONE);
            "}": add_token(TK_RBRACE, cur_offset, LEN_ONE);
            "[": add_token(TK_LBRACK, cur_offset, LEN_ONE);
            "]": add_token(TK_RBRACK, cur_offset, LEN_ONE);
            ";": add_token(TK_SEMI, cur_offset, LEN_ONE);
            ",": add_token(TK_COMMA, cur_offset, LEN_ONE);
            ".": add_token(TK_DOT, cur_offset, LEN_ONE);
            "+": add_token(TK_PLUS, cur_offset, LEN_ONE);
            "-": add_token(TK_MINUS, cur_offset, LEN_ONE);
            "*": add_token(TK_STAR, cur_offset, LEN_ONE);
            "%": add_token(TK_PERCENT, cur_offset, LEN_ONE);
            default:
            begin
                if (letter_char(c))
                begin
                    open_token(M_IDENT);
                    word_text = {40'b0, c};
                end
                else if (digit_char(c))
                    open_token(M_INT);
                else
                    add_token(TK_ERR, cur_offset, LEN_ONE);
            end
        endcase
    endtask

    // Advance the mirror by one accepted byte request, queue its tokens
    task automatic lex_predict(input logic [7:0] c, input logic eoi);
        logic                 at_end;
        logic                 taken;
        logic [KIND_BITS-1:0] single_kind;
        logic [KIND_BITS-1:0] pair_kind;
        logic [7:0]           pair_char;
        lex_token_t           t;
        int                   n;
        if (stream_done)
            return;
        at_end = eoi || (c == CH_NUL);
        taken  = 1'b0;
        step_tokens.delete();
        case (scan_mode)
            M_IDENT:
            begin
                if (!at_end && (letter_char(c) || digit_char(c)))
                begin
                    if (tok_len < LENGTH_BITS'(6))
                        word_text = {word_text[39:0], c};
                    tok_len = grow_len(tok_len, 1);
                    taken   = 1'b1;
                end
                else
                begin
                    add_token(keyword_kind(word_text, tok_len), tok_start, tok_len);
                    scan_mode = M_IDLE;
                end
            end
            M_INT:
            begin
                if (!at_end && digit_char(c))
                begin
                    tok_len = grow_len(tok_len, 1);
                    taken   = 1'b1;
                end
                else if (!at_end && c == ".")
                begin
                    scan_mode = M_INTDOT;
                    taken     = 1'b1;
                end
                else
                begin
                    add_token(TK_INT, tok_start, tok_len);
                    scan_mode = M_IDLE;
                end
            end
            M_INTDOT:
            begin
                // digits then a dot: a digit makes it a float, else int + dot
                if (!at_end && digit_char(c))
                begin
                    tok_len   = grow_len(tok_len, 2);
                    scan_mode = M_FLOAT;
                    taken     = 1'b1;
                end
                else
                begin
                    add_token(TK_INT, tok_start, tok_len);
                    add_token(TK_DOT, cur_offset - 1'b1, LEN_ONE);
                    scan_mode = M_IDLE;
                end
            end
            M_FLOAT:
            begin
                if (!at_end && digit_char(c))
                begin
                    tok_len = grow_len(tok_len, 1);
                    taken   = 1'b1;
                end
                else
                begin
                    add_token(TK_FLOAT, tok_start, tok_len);
                    scan_mode = M_IDLE;
                end
            end
            M_SLASH:
            begin
                if (!at_end && c == "/")
                begin
                    scan_mode = M_COMMENT;
                    taken     = 1'b1;
                end
                else
                begin
                    add_token(TK_SLASH, tok_start, LEN_ONE);
                    scan_mode = M_IDLE;
                end
            end
            M_COMMENT:
            begin
                if (at_end)
                    scan_mode = M_IDLE;
                else
                begin
                    taken = 1'b1;
                    if (c == CH_NL)
                    begin
                        bump_line();
                        scan_mode = M_IDLE;
                    end
                end
            end
            M_LT, M_GT, M_ASSIGN, M_BANG:
            begin
                case (scan_mode)
                    M_LT:     begin single_kind = TK_LT;     pair_kind = TK_LE; end
                    M_GT:     begin single_kind = TK_GT;     pair_kind = TK_GE; end
                    M_ASSIGN: begin single_kind = TK_ASSIGN; pair_kind = TK_EQ; end
                    default:  begin single_kind = TK_BANG;   pair_kind = TK_NE; end
                endcase
                if (!at_end && c == "=")
                begin
                    add_token(pair_kind, tok_start, LEN_TWO);
                    taken = 1'b1;
                end
                else
                    add_token(single_kind, tok_start, LEN_ONE);
                scan_mode = M_IDLE;
            end
            M_AMP, M_PIPE:
            begin
                pair_kind = (scan_mode == M_AMP) ? TK_ANDAND : TK_OROR;
                pair_char = (scan_mode == M_AMP) ? "&" : "|";
                // a lone & or | is an error of length one; the byte is rescanned
                if (!at_end && c == pair_char)
                begin
                    add_token(pair_kind, tok_start, LEN_TWO);
                    taken = 1'b1;
                end
                else
                    add_token(TK_ERR, tok_start, LEN_ONE);
                scan_mode = M_IDLE;
            end
            default: scan_mode = M_IDLE;
        endcase

        if (at_end)
        begin
            add_token(TK_EOF, cur_offset, LEN_ZERO);
            stream_done = 1'b1;
        end
        else
        begin
            if (!taken)
                scan_byte(c);
            cur_offset = cur_offset + 1'b1;
        end

        n = step_tokens.size();
        for (int i = 0; i < n; i++)
        begin
            t      = step_tokens[i];
            t.last = (i == n - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        lex_predict(c, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Token sink: random stall before each request, plus a long hold on demand
    // ------------------------------------------------------------------
    initial
    begin : token_sink
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------
    // Token checker
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= LOG_CAP)
            $display("mismatch %s: expected %0d got %0d (token start %0d)",
                     what, want, got, m_axis_tdata[START_LO +: OFFSET_BITS]);
    endtask

    always @(posedge clk)
    begin : token_checker
        lex_token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tokens.size() == 0)
                note_mismatch("token with none pending", 0, m_axis_tdata[KIND_BITS-1:0]);
            else
            begin
                want = expected_tokens.pop_front();
                if (m_axis_tdata[KIND_BITS-1:0] !== want.kind)
                    note_mismatch("kind", want.kind, m_axis_tdata[KIND_BITS-1:0]);
                if (m_axis_tdata[LINE_LO +: LINE_BITS] !== want.line)
                    note_mismatch("line", want.line, m_axis_tdata[LINE_LO +: LINE_BITS]);
                if (m_axis_tdata[START_LO +: OFFSET_BITS] !== want.start)
                    note_mismatch("start", want.start, m_axis_tdata[START_LO +: OFFSET_BITS]);
                if (m_axis_tdata[LEN_LO +: LENGTH_BITS] !== want.len)
                    note_mismatch("length", want.len, m_axis_tdata[LEN_LO +: LENGTH_BITS]);
                if (m_axis_tlast !== want.last)
                    note_mismatch("tlast", want.last, m_axis_tlast);
            end
        end
    end

    // Watchdog: ends the run if no request moves for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // keywords need the whole word; "iffy" stays an identifier
    task automatic test_keyword_words();
        send_text("if iffy\treturn");
    endtask

    // "&|" is two errors, then doubles and a pending bang
    task automatic test_operator_pairs();
        send_text("&|==<=!");
    endtask

    // int + dot + paren from one byte, then a float
    task automatic test_number_forms();
        send_text("7.(1.5 ");
    endtask

    // skipping carries on after the comment's newline
    task automatic test_line_comment();
        send_text("//x\015\n");
    endtask

    task automatic test_unexpected_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("@", 1'b0);
    endtask

    // sink holds off while bytes that close three tokens keep coming
    task automatic test_output_backpressure();
        sink_hold = 80;
        repeat (12) send_text("7.(");
    endtask

    task automatic send_random_lexeme();
        int    pick;
        int    n;
        string kw;
        pick = $urandom_range(0, 10);
        case (pick)
            0, 1:
            begin
                kw = keyword_texts[$urandom_range(0, 12)];
                n  = $urandom_range(0, 3);
                if (n == 0)
                begin
                    // keyword cut short
                    for (int i = 0; i < kw.len() - 1; i++)
                        send_byte(kw[i], 1'b0);
                end
                else
                begin
                    send_text(kw);
                    if (n == 1)
                        send_byte(word_chars[$urandom_range(0, 62)], 1'b0);
                end
            end
            2:
            begin
                send_byte(word_chars[$urandom_range(0, 52)], 1'b0);
                repeat ($urandom_range(0, 7))
                    send_byte(word_chars[$urandom_range(0, 62)], 1'b0);
            end
            3, 4:
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                if (pick == 4)
                begin
                    send_byte(".", 1'b0);
                    // sometimes no fraction, so the next lexeme decides
                    repeat ($urandom_range(0, 3))
                        send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            end
            5, 6, 7: send_text(op_texts[$urandom_range(0, 25)]);
            8:
            begin
                send_text("//");
                repeat ($urandom_range(0, 10))
                begin
                    n = $urandom_range(1, 255);
                    send_byte((n == CH_NL) ? 8'("c") : 8'(n), 1'b0);
                end
                send_byte(CH_NL, 1'b0);
            end
            9:
                repeat ($urandom_range(1, 3))
                    send_byte(ws_chars[$urandom_range(0, 3)], 1'b0);
            default: send_byte(8'($urandom_range(1, 255)), 1'b0);
        endcase
        if ($urandom_range(0, 1))
            send_byte(ws_chars[$urandom_range(0, 3)], 1'b0);
    endtask

    task automatic test_random_lexemes();
        int target;
        target = bytes_sent + 360;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 39) == 0)
                steady_flow = !steady_flow;
            send_random_lexeme();
        end
        steady_flow = 1'b0;
    endtask

    // flush of int + dot + EOF from one request; later requests are ignored
    task automatic test_end_of_input();
        send_text("12.");
        if ($urandom_range(0, 1))
            send_byte(CH_NUL, 1'b0);
        else
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte("a", 1'b0);
        send_byte(CH_NUL, 1'b1);
    endtask

    initial
    begin : run
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keyword_words();
        test_operator_pairs();
        test_number_forms();
        test_line_comment();
        test_unexpected_bytes();
        test_output_backpressure();
        test_random_lexemes();
        test_end_of_input();

        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/csl_pkg.sv
hw/rtl/c_subset_lexer_core.sv
sim/tb_top.sv
